### hdl/prsc_pkg.sv
// Shared types and constants of the roll-to-steer PID controller.
// No dependencies; every other file but prsc_div refers to it by scoped names.
package prsc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegGainP    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSetpoint = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDriveMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDriveMin = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSteerMax = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSteerMin = 3'd7;

  localparam logic signed [31:0] WindupLimit   = 32'sd655360;
  localparam logic        [31:0] MinIntervalMs = 32'd10;

  // Divide by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38,
  // exact for any dividend below 2^32
  localparam logic signed [32:0] RecipMs    = 33'sd274877907;
  localparam int unsigned        RecipShift = 38;

  typedef struct packed {
    logic        [30:0] gain_p;
    logic        [30:0] gain_i;
    logic        [30:0] gain_d;
    logic signed [31:0] roll_setpoint;
    logic signed [31:0] drive_max;
    logic signed [31:0] drive_min;
    logic signed [31:0] steer_max;
    logic signed [31:0] steer_min;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ERR, OP_MUL_P, OP_ACC_P, OP_MUL_T, OP_DIV_T, OP_INT,
    OP_MUL_I, OP_ACC_I, OP_MUL_D, OP_SCL_D, OP_DIV_D, OP_ACC_D, OP_CLAMP,
    OP_MUL_S, OP_DIV_S, OP_STEER, OP_HOLD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic prev_valid;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

### hdl/pid_roll_to_steer_controller.sv
// Top level of the roll-to-steer PID controller: register bank, sequencer, datapath.
// Depends on prsc_pkg, prsc_regs, prsc_ctrl and prsc_dpath.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  roll, time_ms
//  m_axis    out        m_axis_tvalid/m_axis_tready  steer, updated
//  cfg       in         cfg_valid_i/cfg_ready_o      register index, write data
//
// An early sample (under 10 ms since the last update) repeats the held steer value.
// A PID step makes two passes through the bit-serial divider, one on the first step,
// which has no derivative.
// Reset clears the PID state and the held steer value and returns the config
// registers to their defaults.
// A full output register stalls only the final write; the next beat is taken
// once the step has handed its result over.
module pid_roll_to_steer_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] roll, [63:32] time_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] steer
  output logic        m_axis_tuser,   // [0] updated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [prsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  prsc_pkg::cfg_t    cfg;
  prsc_pkg::cmd_t    cmd;
  prsc_pkg::status_t status;

  // Register writes land in any cycle
  assign cfg_ready_o = 1'b1;

  prsc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  prsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prsc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

### hdl/prsc_regs.sv
// Configuration register bank of the roll-to-steer controller.
// Depends on prsc_pkg.
module prsc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [prsc_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [31:0]                   wr_data_i,
  output prsc_pkg::cfg_t                cfg_o
);

  prsc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= 31'd65536;
      cfg_q.gain_i        <= 31'd0;
      cfg_q.gain_d        <= 31'd0;
      cfg_q.roll_setpoint <= 32'sd0;
      cfg_q.drive_max     <= 32'sd65536;
      cfg_q.drive_min     <= -32'sd65536;
      cfg_q.steer_max     <= 32'sd65536;
      cfg_q.steer_min     <= -32'sd65536;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        prsc_pkg::RegGainP:    cfg_q.gain_p        <= wr_data_i[30:0];
        prsc_pkg::RegGainI:    cfg_q.gain_i        <= wr_data_i[30:0];
        prsc_pkg::RegGainD:    cfg_q.gain_d        <= wr_data_i[30:0];
        prsc_pkg::RegSetpoint: cfg_q.roll_setpoint <= wr_data_i;
        prsc_pkg::RegDriveMax: cfg_q.drive_max     <= wr_data_i;
        prsc_pkg::RegDriveMin: cfg_q.drive_min     <= wr_data_i;
        prsc_pkg::RegSteerMax: cfg_q.steer_max     <= wr_data_i;
        prsc_pkg::RegSteerMin: cfg_q.steer_min     <= wr_data_i;
        default:               cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/prsc_div.sv
// Signed 64 by 33 bit divider, one quotient bit per cycle, truncating.
// No dependencies.
module prsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic signed [32:0] divisor_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [31:0] den_q, rem_q;
  logic [63:0] dq_q;
  logic [32:0] trial;
  logic [32:0] den_abs;
  logic [63:0] dvd_abs;

  assign trial   = {rem_q, dq_q[63]};
  assign den_abs = divisor_i[32] ? -divisor_i : divisor_i;
  assign dvd_abs = dividend_i[63] ? -dividend_i : dividend_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dvd_abs;
      den_q <= den_abs[31:0];
      rem_q <= '0;
      neg_q <= dividend_i[63] ^ divisor_i[32];
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= 32'(trial - {1'b0, den_q});
        dq_q  <= {dq_q[62:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        dq_q  <= {dq_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dq_q) : $signed(dq_q);

endmodule

### hdl/prsc_dpath.sv
// Datapath: shared multiplier, accumulator, PID state and output register.
// Depends on prsc_pkg and prsc_div.
module prsc_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prsc_pkg::cfg_t     cfg_i,
  input  prsc_pkg::cmd_t     cmd_i,
  output prsc_pkg::status_t  status_o,
  input  logic [63:0]        in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_data_o,
  output logic               out_user_o
);

  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'(QMax)) return QMax;
    if (x < 64'(QMin)) return QMin;
    return x[31:0];
  endfunction

  logic signed [31:0] roll_q, e_q, integ_q, prev_q, sum_q, den_q, held_q;
  logic        [31:0] time_q, elapsed_q, last_q, out_data_q;
  logic signed [63:0] prod_q, acc_q;
  logic               prev_valid_q, out_valid_q, out_user_q;
  logic               t_neg_q, t_big_q;

  logic signed [32:0] mul_a, mul_b, div_den;
  logic signed [65:0] mul_full;
  logic signed [32:0] err_wide;
  logic signed [63:0] prod_sh, integ_sum, quot, steer_num;
  logic        [63:0] t_mag;
  logic signed [63:0] t_quo, t_inc;
  logic signed [31:0] steer;
  logic               div_start, div_done;

  assign err_wide = 33'(cfg_i.roll_setpoint) - 33'(roll_q);
  assign prod_sh  = prod_q >>> 16;
  assign steer_num = prod_q;

  // Integral increment: magnitude of error*elapsed, divided by 1000 through the
  // reciprocal. A magnitude of 2^31 or more drives the integral into its clamp.
  assign t_mag     = prod_q[63] ? -prod_q : prod_q;
  assign t_quo     = prod_q >>> prsc_pkg::RecipShift;
  assign t_inc     = t_neg_q ? -t_quo : t_quo;
  assign integ_sum = 64'(integ_q) + t_inc;

  // Operand selection of the shared multiplier
  always_comb begin
    mul_a = 33'(e_q);
    mul_b = '0;
    unique case (cmd_i.op)
      prsc_pkg::OP_MUL_P: mul_b = {2'b00, cfg_i.gain_p};
      prsc_pkg::OP_MUL_T: mul_b = {1'b0, elapsed_q};
      prsc_pkg::OP_DIV_T: begin
        mul_a = {2'b00, t_mag[30:0]};
        mul_b = prsc_pkg::RecipMs;
      end
      prsc_pkg::OP_MUL_I: begin
        mul_a = 33'(integ_q);
        mul_b = {2'b00, cfg_i.gain_i};
      end
      prsc_pkg::OP_MUL_D: begin
        mul_a = 33'(e_q) - 33'(prev_q);
        mul_b = {2'b00, cfg_i.gain_d};
      end
      prsc_pkg::OP_MUL_S: begin
        mul_a = 33'(sum_q);
        mul_b = sum_q[31] ? 33'(cfg_i.steer_max) : 33'(cfg_i.steer_min);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_comb begin
    unique case (cmd_i.op)
      prsc_pkg::OP_DIV_D: div_den = {1'b0, elapsed_q};
      default:            div_den = 33'(den_q);
    endcase
  end

  assign div_start = (cmd_i.op == prsc_pkg::OP_DIV_D) || (cmd_i.op == prsc_pkg::OP_DIV_S);

  prsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Zero divisor counts as positive: saturate toward the numerator's sign
  always_comb begin
    if (den_q == 32'sd0) begin
      if (steer_num == 64'sd0) steer = 32'sd0;
      else if (steer_num < 64'sd0) steer = QMin;
      else steer = QMax;
    end else begin
      steer = sat32(quot);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      prsc_pkg::OP_LOAD: begin
        roll_q    <= in_data_i[31:0];
        time_q    <= in_data_i[63:32];
        elapsed_q <= in_data_i[63:32] - last_q;
      end
      prsc_pkg::OP_ERR:   e_q <= sat32(64'(err_wide));
      prsc_pkg::OP_MUL_P, prsc_pkg::OP_MUL_T, prsc_pkg::OP_MUL_I, prsc_pkg::OP_MUL_D:
        prod_q <= mul_full[63:0];
      prsc_pkg::OP_DIV_T: begin
        prod_q  <= mul_full[63:0];
        t_neg_q <= prod_q[63];
        t_big_q <= |t_mag[63:31];
      end
      prsc_pkg::OP_MUL_S: begin
        prod_q <= mul_full[63:0];
        den_q  <= sum_q[31] ? cfg_i.drive_min : cfg_i.drive_max;
      end
      prsc_pkg::OP_ACC_P: acc_q <= prod_sh;
      prsc_pkg::OP_ACC_I: acc_q <= acc_q + prod_sh;
      prsc_pkg::OP_ACC_D: acc_q <= acc_q + quot;
      // Times 1000 as shifts: 1024 - 16 - 8
      prsc_pkg::OP_SCL_D: prod_q <= (prod_sh <<< 10) - (prod_sh <<< 4) - (prod_sh <<< 3);
      prsc_pkg::OP_CLAMP: begin
        if (acc_q > 64'(cfg_i.drive_max))      sum_q <= cfg_i.drive_max;
        else if (acc_q < 64'(cfg_i.drive_min)) sum_q <= cfg_i.drive_min;
        else                                   sum_q <= acc_q[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= '0;
      integ_q      <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      held_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_user_q   <= 1'b0;
    end else begin
      if ((cmd_i.op == prsc_pkg::OP_STEER) || (cmd_i.op == prsc_pkg::OP_HOLD)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        prsc_pkg::OP_INT: begin
          if (t_big_q) begin
            integ_q <= t_neg_q ? -prsc_pkg::WindupLimit : prsc_pkg::WindupLimit;
          end else if (integ_sum > 64'(prsc_pkg::WindupLimit)) begin
            integ_q <= prsc_pkg::WindupLimit;
          end else if (integ_sum < -64'(prsc_pkg::WindupLimit)) begin
            integ_q <= -prsc_pkg::WindupLimit;
          end else begin
            integ_q <= integ_sum[31:0];
          end
        end
        prsc_pkg::OP_CLAMP: begin
          prev_q       <= e_q;
          prev_valid_q <= 1'b1;
          last_q       <= time_q;
        end
        prsc_pkg::OP_STEER: begin
          held_q      <= steer;
          out_data_q  <= steer;
          out_user_q  <= 1'b1;
        end
        prsc_pkg::OP_HOLD: begin
          out_data_q  <= held_q;
          out_user_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign status_o.early      = elapsed_q < prsc_pkg::MinIntervalMs;
  assign status_o.prev_valid = prev_valid_q;
  assign status_o.div_done   = div_done;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

### hdl/prsc_ctrl.sv
// PID step sequencer: issues datapath commands, waits on divider and output.
// Depends on prsc_pkg.
module prsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  prsc_pkg::status_t  status_i,
  output prsc_pkg::cmd_t     cmd_o
);

  localparam logic [4:0] StIdle  = 5'd0,  StChk   = 5'd1,  StErr   = 5'd2,
                         StMulP  = 5'd3,  StAccP  = 5'd4,  StMulT  = 5'd5,
                         StDivT  = 5'd6,  StInt   = 5'd8,
                         StMulI  = 5'd9,  StAccI  = 5'd10, StMulD  = 5'd11,
                         StSclD  = 5'd12, StDivD  = 5'd13, StWaitD = 5'd14,
                         StAccD  = 5'd15, StClamp = 5'd16, StMulS  = 5'd17,
                         StDivS  = 5'd18, StWaitS = 5'd19, StSteer = 5'd20,
                         StHold  = 5'd21;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = prsc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = prsc_pkg::OP_LOAD;
          state_d  = StChk;
        end
      end
      StChk:   state_d = status_i.early ? StHold : StErr;
      StErr:   begin cmd_o.op = prsc_pkg::OP_ERR;   state_d = StMulP; end
      StMulP:  begin cmd_o.op = prsc_pkg::OP_MUL_P; state_d = StAccP; end
      StAccP:  begin cmd_o.op = prsc_pkg::OP_ACC_P; state_d = StMulT; end
      StMulT:  begin cmd_o.op = prsc_pkg::OP_MUL_T; state_d = StDivT; end
      StDivT:  begin cmd_o.op = prsc_pkg::OP_DIV_T; state_d = StInt; end
      StInt:   begin cmd_o.op = prsc_pkg::OP_INT;   state_d = StMulI; end
      StMulI:  begin cmd_o.op = prsc_pkg::OP_MUL_I; state_d = StAccI; end
      StAccI: begin
        cmd_o.op = prsc_pkg::OP_ACC_I;
        state_d  = status_i.prev_valid ? StMulD : StClamp;
      end
      StMulD:  begin cmd_o.op = prsc_pkg::OP_MUL_D; state_d = StSclD; end
      StSclD:  begin cmd_o.op = prsc_pkg::OP_SCL_D; state_d = StDivD; end
      StDivD:  begin cmd_o.op = prsc_pkg::OP_DIV_D; state_d = StWaitD; end
      StWaitD: if (status_i.div_done) state_d = StAccD;
      StAccD:  begin cmd_o.op = prsc_pkg::OP_ACC_D; state_d = StClamp; end
      StClamp: begin cmd_o.op = prsc_pkg::OP_CLAMP; state_d = StMulS; end
      StMulS:  begin cmd_o.op = prsc_pkg::OP_MUL_S; state_d = StDivS; end
      StDivS:  begin cmd_o.op = prsc_pkg::OP_DIV_S; state_d = StWaitS; end
      StWaitS: if (status_i.div_done) state_d = StSteer;
      StSteer: if (!status_i.out_busy) begin
        cmd_o.op = prsc_pkg::OP_STEER;
        state_d  = StIdle;
      end
      StHold: if (!status_i.out_busy) begin
        cmd_o.op = prsc_pkg::OP_HOLD;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule
